[sv/btpc_pkg.sv]
// Package for the barometric compensation core: payload structs, coefficient
// helpers and shared constants. Used by every module of the block.
package btpc_pkg;

   localparam int DivBits = 64;

   typedef struct packed {
      logic [19:0] raw_pressure;
      logic [19:0] raw_temperature;
   } req_payload_type;

   typedef struct packed {
      logic        pressure_valid;
      logic [31:0] pressure_q24_8;
      logic signed [31:0] fine_temperature;
      logic signed [31:0] temperature_centi;
   } rsp_payload_type;

   localparam logic [1:0] CsrTempCal  = 2'd0;
   localparam logic [1:0] CsrPressLow = 2'd1;
   localparam logic [1:0] CsrPressHi  = 2'd2;
   localparam logic [1:0] CsrPressP9  = 2'd3;

   function automatic logic signed [63:0] sx16(input logic [15:0] v);
      sx16 = {{48{v[15]}}, v};
   endfunction

endpackage

[sv/btpc_div.sv]
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating.
// Depends on btpc_pkg for the divider width. Carries a sideband word.
module btpc_div (
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic         in_valid,
   input  logic [63:0]  in_num,
   input  logic [63:0]  in_den,
   input  logic [127:0] in_side,
   output logic         out_valid,
   output logic [63:0]  out_quot,
   output logic [127:0] out_side
);
   localparam int N = btpc_pkg::DivBits;

   logic [N:0]         valid_ff;
   logic [63:0]        rem_ff  [N+1];
   logic [63:0]        quo_ff  [N+1];
   logic [63:0]        den_ff  [N+1];
   logic               neg_ff  [N+1];
   logic [127:0]       side_ff [N+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[N-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0]  <= '0;
         quo_ff[0]  <= in_num[63] ? (64'd0 - in_num) : in_num;
         den_ff[0]  <= in_den[63] ? (64'd0 - in_den) : in_den;
         neg_ff[0]  <= in_num[63] ^ in_den[63];
         side_ff[0] <= in_side;
      end
   end

   // Restoring division: each stage shifts in one dividend bit.
   for (genvar s = 0; s < N; s++) begin : g_stage
      logic [64:0] trial;
      logic [64:0] part;
      assign part  = {rem_ff[s], quo_ff[s][63]};
      assign trial = part - {1'b0, den_ff[s]};
      always_ff @(posedge clock) begin
         if (advance) begin
            if (!trial[64]) begin
               rem_ff[s+1] <= trial[63:0];
            end else begin
               rem_ff[s+1] <= part[63:0];
            end
            quo_ff[s+1]  <= {quo_ff[s][62:0], ~trial[64]};
            den_ff[s+1]  <= den_ff[s];
            neg_ff[s+1]  <= neg_ff[s];
            side_ff[s+1] <= side_ff[s];
         end
      end
   end

   assign out_valid = valid_ff[N];
   assign out_quot  = neg_ff[N] ? (64'd0 - quo_ff[N]) : quo_ff[N];
   assign out_side  = side_ff[N];
endmodule

[sv/baro_temp_pressure_compensation_core.sv]
// Top level of the barometric compensation core: temperature stages, pressure
// front stages, the pipelined divider and the pressure tail. Uses btpc_pkg, btpc_div.
//
//   channel | direction | handshake         | payload
//   req     | in        | req_valid/ready   | btpc_pkg::req_payload_type
//   rsp     | out       | rsp_valid/ready   | btpc_pkg::rsp_payload_type
//   csr     | in        | csr_valid/ready   | csr_index, csr_data
//
// One item enters per cycle while the pipeline advances. The accepting edge writes the first
// of 84 registers: 10 front stages, 65 divider stages, 8 tail stages and the output
// register, which presents the result. The divider's one-bit-per-stage chain sets
// the depth. Reset is synchronous and clears valid bits and calibration.
// The whole pipeline advances only when the output slot is empty or taken,
// so a stall holds every stage and nothing is lost or repeated.
module baro_temp_pressure_compensation_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  btpc_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output btpc_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [1:0]                csr_index,
   input  logic [63:0]               csr_data
);
   logic [47:0] tcal_ff;
   logic [63:0] plo_ff, phi_ff;
   logic [15:0] p9_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         tcal_ff <= '0; plo_ff <= '0; phi_ff <= '0; p9_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            btpc_pkg::CsrTempCal:  tcal_ff <= csr_data[47:0];
            btpc_pkg::CsrPressLow: plo_ff  <= csr_data;
            btpc_pkg::CsrPressHi:  phi_ff  <= csr_data;
            btpc_pkg::CsrPressP9:  p9_ff   <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   logic signed [31:0] t1, t2, t3;
   logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
   assign t1 = {16'd0, tcal_ff[15:0]};
   assign t2 = {{16{tcal_ff[31]}}, tcal_ff[31:16]};
   assign t3 = {{16{tcal_ff[47]}}, tcal_ff[47:32]};
   assign p1 = {48'd0, plo_ff[15:0]};
   assign p2 = btpc_pkg::sx16(plo_ff[31:16]);
   assign p3 = btpc_pkg::sx16(plo_ff[47:32]);
   assign p4 = btpc_pkg::sx16(plo_ff[63:48]);
   assign p5 = btpc_pkg::sx16(phi_ff[15:0]);
   assign p6 = btpc_pkg::sx16(phi_ff[31:16]);
   assign p7 = btpc_pkg::sx16(phi_ff[47:32]);
   assign p8 = btpc_pkg::sx16(phi_ff[63:48]);
   assign p9 = btpc_pkg::sx16(p9_ff);

   // Output register and global advance.
   logic advance;
   logic out_v_ff;
   btpc_pkg::rsp_payload_type out_ff;
   assign advance   = !out_v_ff || rsp_ready;
   assign req_ready = advance;

   localparam int FS = 10;
   logic [FS-1:0] fv_ff;
   always_ff @(posedge clock) begin
      if (reset) fv_ff <= '0;
      else if (advance) fv_ff <= {fv_ff[FS-2:0], req_valid};
   end

   // Front stages. Stage numbers name the register written.
   logic [19:0] adcp_ff [FS-1];
   logic signed [31:0] a1_ff, c1_ff, m2a_ff, m2c_ff, v1t3_ff, cc3_ff, x4_ff;
   logic signed [31:0] v1t4_ff, v1t5_ff, fine_ff [FS+1], centi_ff [FS+1];
   logic signed [31:0] y5_ff;
   // The temperature terms are small enough that their sum never wraps at 32 bits.
   logic signed [32:0] v6_ff;
   logic signed [63:0] vv7_ff, vp5_7_ff, vp2_7_ff;
   logic signed [63:0] a8_ff, b8_ff, c8_ff, d8_ff, v2_9_ff, v1_9_ff;
   logic signed [63:0] num_ff, v1_10_ff;
   logic signed [63:0] pdiff;

   assign pdiff = 64'sd1048576 - $signed({44'd0, adcp_ff[FS-2]});

   always_ff @(posedge clock) begin
      if (advance) begin
         adcp_ff[0] <= req_payload.raw_pressure;
         for (int i = 1; i <= FS - 2; i++) adcp_ff[i] <= adcp_ff[i-1];
         // 1
         a1_ff <= $signed({15'd0, req_payload.raw_temperature[19:3]}) - (t1 <<< 1);
         c1_ff <= $signed({16'd0, req_payload.raw_temperature[19:4]}) - t1;
         // 2
         m2a_ff <= a1_ff * t2;
         m2c_ff <= c1_ff * c1_ff;
         // 3
         v1t3_ff <= m2a_ff >>> 11;
         cc3_ff  <= m2c_ff >>> 12;
         // 4
         v1t4_ff <= v1t3_ff;
         x4_ff   <= cc3_ff * t3;
         // 5
         v1t5_ff <= v1t4_ff;
         y5_ff   <= x4_ff >>> 14;
         // 6: fine temperature
         fine_ff[6] <= v1t5_ff + y5_ff;
         v6_ff      <= {v1t5_ff[31], v1t5_ff} + {y5_ff[31], y5_ff} - 33'sd128000;
         // 7
         centi_ff[7] <= (fine_ff[6] * 32'sd5 + 32'sd128) >>> 8;
         fine_ff[7]  <= fine_ff[6];
         vv7_ff      <= v6_ff * v6_ff;
         vp5_7_ff    <= v6_ff * p5;
         vp2_7_ff    <= v6_ff * p2;
         // 8
         a8_ff <= vv7_ff * p6;
         b8_ff <= vv7_ff * p3;
         c8_ff <= vp5_7_ff <<< 17;
         d8_ff <= vp2_7_ff <<< 12;
         // 9
         v2_9_ff <= a8_ff + c8_ff + (p4 <<< 35);
         v1_9_ff <= (b8_ff >>> 8) + d8_ff + (64'sd1 <<< 47);
         // 10: dividend and divisor
         num_ff   <= ((pdiff <<< 31) - v2_9_ff) * 64'sd3125;
         v1_10_ff <= (v1_9_ff * p1) >>> 33;
         centi_ff[8] <= centi_ff[7]; centi_ff[9] <= centi_ff[8];
         centi_ff[10] <= centi_ff[9];
         fine_ff[8] <= fine_ff[7]; fine_ff[9] <= fine_ff[8];
         fine_ff[10] <= fine_ff[9];
      end
   end

   logic         dv;
   logic [63:0]  dq;
   logic [127:0] dside;
   btpc_div u_div (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(fv_ff[FS-1]), .in_num(num_ff), .in_den(v1_10_ff),
      .in_side({centi_ff[FS], fine_ff[FS], 63'd0, (v1_10_ff != 64'sd0)}),
      .out_valid(dv), .out_quot(dq), .out_side(dside)
   );

   // Tail stages.
   localparam int TS = 8;
   logic [TS:1] tv_ff;
   logic [127:0] ts_ff [TS+1];
   logic signed [63:0] p1t_ff, s2_ff, m2_ff, m3_ff, m3b_ff, v1r_ff, v2r_ff, sum_ff;
   logic signed [63:0] p2t_ff, p3t_ff, p4t_ff, p6t_ff;
   logic signed [63:0] w4_ff, w6_ff;
   logic [63:0] ll3_ff;
   logic [31:0] cr3_ff;

   always_ff @(posedge clock) begin
      if (reset) tv_ff <= '0;
      else if (advance) tv_ff <= {tv_ff[TS-1:1], dv};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ts_ff[1] <= dside;
         for (int i = 2; i <= TS; i++) ts_ff[i] <= ts_ff[i-1];
         p1t_ff  <= dq;
         s2_ff   <= p1t_ff >>> 13;
         p2t_ff  <= p1t_ff;
         m2_ff   <= p9 * (p1t_ff >>> 13);
         // The wrapped 64-bit product of m2 and s2 is built from 32-bit halves.
         ll3_ff  <= m2_ff[31:0] * s2_ff[31:0];
         cr3_ff  <= m2_ff[63:32] * s2_ff[31:0] + m2_ff[31:0] * s2_ff[63:32];
         m3b_ff  <= p8 * p2t_ff;
         p3t_ff  <= p2t_ff;
         m3_ff   <= $signed(ll3_ff + {cr3_ff, 32'd0});
         v2r_ff  <= m3b_ff >>> 19;
         p4t_ff  <= p3t_ff;
         v1r_ff  <= m3_ff >>> 25;
         w4_ff   <= p4t_ff + v2r_ff;
         sum_ff  <= w4_ff + v1r_ff;
         w6_ff   <= (sum_ff >>> 8) + (p7 <<< 4);
         p6t_ff  <= w6_ff;
      end
   end

   logic [127:0] side_last;
   assign side_last = ts_ff[TS];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (advance) begin
         out_v_ff <= tv_ff[TS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff.temperature_centi <= side_last[127:96];
         out_ff.fine_temperature  <= side_last[95:64];
         out_ff.pressure_valid    <= side_last[0];
         out_ff.pressure_q24_8    <= side_last[0] ? p6t_ff[31:0] : 32'd0;
      end
   end

   assign rsp_valid   = out_v_ff;
   assign rsp_payload = out_ff;

`ifndef NO_ASSERTIONS
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result item changed while stalled");
   a_ready_tracks: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not follow output slot");
   a_zero_press: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.pressure_valid |-> rsp_payload.pressure_q24_8 == 32'd0)
      else $error("invalid pressure not forced to zero");
`endif
endmodule
